// ===== hdl/wdpr_pkg.sv =====
// Package for the wall distance pose reset block: constants, types and helper functions.
package wdpr_pkg;

   // CORDIC steps, taken from the heading angle resolution
   localparam int ANGLE_BITS = 16;
   localparam int ITER = (ANGLE_BITS < 24) ? ANGLE_BITS : 24;

   localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
   localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
   localparam logic [25:0] MM_RECIP = 26'd33818641; // ceil(2^32 / 127)
   localparam logic [14:0] SPAN_RESET = 15'd17920;

   localparam logic [1:0] WALL_TOP = 2'd0;
   localparam logic [1:0] WALL_BOTTOM = 2'd1;
   localparam logic [1:0] WALL_LEFT = 2'd2;
   localparam logic [1:0] WALL_RIGHT = 2'd3;

   localparam logic [1:0] SENSOR_FRONT = 2'd0;
   localparam logic [1:0] SENSOR_REAR = 2'd1;
   localparam logic [1:0] SENSOR_LEFT = 2'd2;
   localparam logic [1:0] SENSOR_RIGHT = 2'd3;

   // request fields carried alongside the CORDIC
   typedef struct packed {
      logic [17:0]        dist_q8;
      logic [1:0]         sensor_side;
      logic [1:0]         wall_side;
      logic               sensor_present;
      logic signed [15:0] mount_x_offset;
      logic signed [15:0] mount_y_offset;
      logic signed [15:0] pose_x_in;
      logic signed [15:0] pose_y_in;
      logic [14:0]        gate_distance;
   } side_type;

   typedef struct packed {
      logic signed [32:0] x;
      logic signed [32:0] y;
      logic [1:0]         quad;
      side_type           side;
   } rot_type;

   typedef struct packed {
      logic signed [15:0] candidate_pos;
      logic               axis_is_y;
      logic               accepted;
      logic signed [15:0] pose_x_out;
      logic signed [15:0] pose_y_out;
   } result_type;

   typedef struct packed {
      logic signed [17:0] c;
      logic signed [17:0] s;
   } trig_type;

   // arctangent of 2^-i, binary angle of 2^32 per turn
   function automatic logic signed [32:0] atan_step(input int i);
      logic signed [32:0] r;
      case (i)
         0: r = 33'sd536870912;
         1: r = 33'sd316933406;
         2: r = 33'sd167458907;
         3: r = 33'sd85004756;
         4: r = 33'sd42667331;
         5: r = 33'sd21354465;
         6: r = 33'sd10679838;
         7: r = 33'sd5340245;
         8: r = 33'sd2670163;
         9: r = 33'sd1335087;
         10: r = 33'sd667544;
         11: r = 33'sd333772;
         12: r = 33'sd166886;
         13: r = 33'sd83443;
         14: r = 33'sd41722;
         15: r = 33'sd20861;
         16: r = 33'sd10430;
         17: r = 33'sd5215;
         18: r = 33'sd2608;
         19: r = 33'sd1304;
         20: r = 33'sd652;
         21: r = 33'sd326;
         22: r = 33'sd163;
         23: r = 33'sd81;
         default: r = 33'sd0;
      endcase
      return r;
   endfunction

   // rotate a cosine/sine pair by a number of quarter turns
   function automatic trig_type quarter_rotate(input logic signed [17:0] c,
                                               input logic signed [17:0] s,
                                               input logic [1:0] q);
      trig_type r;
      case (q)
         2'd1: begin
            r.c = -s;
            r.s = c;
         end
         2'd2: begin
            r.c = -c;
            r.s = -s;
         end
         2'd3: begin
            r.c = s;
            r.s = -c;
         end
         default: begin
            r.c = c;
            r.s = s;
         end
      endcase
      return r;
   endfunction

   // sensor mounting angle in quarter turns
   function automatic logic [1:0] sensor_quarter(input logic [1:0] side);
      logic [1:0] r;
      case (side)
         SENSOR_FRONT: r = 2'd0;
         SENSOR_REAR: r = 2'd2;
         SENSOR_LEFT: r = 2'd1;
         SENSOR_RIGHT: r = 2'd3;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/wdpr_req_if.sv =====
// Request channel interface: valid, ready and the reset request word.
interface wdpr_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        heading;
   logic [13:0]        distance_mm;
   logic [1:0]         sensor_side;
   logic [1:0]         wall_side;
   logic               sensor_present;
   logic signed [15:0] mount_x_offset;
   logic signed [15:0] mount_y_offset;
   logic signed [15:0] pose_x_in;
   logic signed [15:0] pose_y_in;
   logic [14:0]        gate_distance;

   modport source (output valid, heading, distance_mm, sensor_side, wall_side, sensor_present,
                   mount_x_offset, mount_y_offset, pose_x_in, pose_y_in, gate_distance,
                   input ready);
   modport sink (input valid, heading, distance_mm, sensor_side, wall_side, sensor_present,
                 mount_x_offset, mount_y_offset, pose_x_in, pose_y_in, gate_distance,
                 output ready);
endinterface

// ===== hdl/wdpr_rsp_if.sv =====
// Response channel interface: valid, ready and the pose result word.
interface wdpr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] candidate_pos;
   logic               axis_is_y;
   logic               accepted;
   logic signed [15:0] pose_x_out;
   logic signed [15:0] pose_y_out;

   modport source (output valid, candidate_pos, axis_is_y, accepted, pose_x_out, pose_y_out,
                   input ready);
   modport sink (input valid, candidate_pos, axis_is_y, accepted, pose_x_out, pose_y_out,
                 output ready);
endinterface

// ===== hdl/wdpr_cordic.sv =====
// Entry stage and pipelined CORDIC for the heading sine and cosine.
module wdpr_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [15:0]         heading,
   input  logic [13:0]         distance_mm,
   input  wdpr_pkg::side_type  side_in,
   output logic                out_valid,
   output wdpr_pkg::rot_type   out_word
);

   localparam int N = wdpr_pkg::ITER;

   logic                 valid_ff [0:N];
   logic signed [32:0]   x_ff [0:N];
   logic signed [32:0]   y_ff [0:N];
   logic signed [32:0]   z_ff [0:N];
   logic [1:0]           quad_ff [0:N];
   wdpr_pkg::side_type   side_ff [0:N];

   logic [31:0]          angle;
   logic [31:0]          angle_round;
   logic [1:0]           quad_in;
   logic [31:0]          resid;
   logic [24:0]          mm_scaled;
   logic [50:0]          mm_prod;
   wdpr_pkg::side_type   side_entry;

   // split angle into nearest quarter turn and residue, convert mm to inches*256
   always_comb begin
      angle       = {heading, 16'd0} & wdpr_pkg::ANGLE_MASK;
      angle_round = angle + 32'h2000_0000;
      quad_in     = angle_round[31:30];
      resid       = angle - {quad_in, 30'd0};
      mm_scaled   = {1'b0, distance_mm, 10'd0} + {3'd0, distance_mm, 8'd0} + 25'd63;
      mm_prod     = {26'd0, mm_scaled} * {25'd0, wdpr_pkg::MM_RECIP};
      side_entry  = side_in;
      side_entry.dist_q8 = mm_prod[49:32];
   end

   // load entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
      if (advance) begin
         x_ff[0]    <= wdpr_pkg::CORDIC_X0;
         y_ff[0]    <= 33'sd0;
         z_ff[0]    <= {resid[31], resid};
         quad_ff[0] <= quad_in;
         side_ff[0] <= side_entry;
      end
   end

   // one rotation step per stage
   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] x_in;
      logic signed [32:0] y_in;
      logic signed [32:0] z_in;

      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         if (!z_ff[i][32]) begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - wdpr_pkg::atan_step(i);
         end else begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + wdpr_pkg::atan_step(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (advance) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            quad_ff[i+1] <= quad_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid     = valid_ff[N];
   assign out_word.x    = x_ff[N];
   assign out_word.y    = y_ff[N];
   assign out_word.quad = quad_ff[N];
   assign out_word.side = side_ff[N];

endmodule

// ===== hdl/wdpr_post.sv =====
// Quarter rotation, products, sum, rounding and gating stages with the result register.
module wdpr_post (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [14:0]          wall_half_span,
   input  logic                 in_valid,
   input  wdpr_pkg::rot_type    in_word,
   output logic                 out_valid,
   output wdpr_pkg::result_type out_word
);

   // stage 1: trig
   logic                 s1_valid_ff;
   logic signed [17:0]   s1_ch_ff, s1_sh_ff, s1_t_ff;
   logic signed [15:0]   s1_wpos_ff;
   logic                 s1_axis_ff;
   wdpr_pkg::side_type   s1_side_ff;

   logic [32:0]          xr_sum, yr_sum;
   wdpr_pkg::trig_type   hd_in, th_in;
   logic                 axis_in;
   logic [1:0]           tq_in;
   logic signed [15:0]   wpos_in;

   always_comb begin
      xr_sum  = in_word.x + 33'sd16384;
      yr_sum  = in_word.y + 33'sd16384;
      hd_in   = wdpr_pkg::quarter_rotate($signed(xr_sum[32:15]), $signed(yr_sum[32:15]),
                                         in_word.quad);
      axis_in = (in_word.side.wall_side == wdpr_pkg::WALL_TOP) ||
                (in_word.side.wall_side == wdpr_pkg::WALL_BOTTOM);
      tq_in   = (axis_in ? 2'd3 : 2'd1) + wdpr_pkg::sensor_quarter(in_word.side.sensor_side);
      th_in   = wdpr_pkg::quarter_rotate(hd_in.c, hd_in.s, tq_in);
      if ((in_word.side.wall_side == wdpr_pkg::WALL_TOP) ||
          (in_word.side.wall_side == wdpr_pkg::WALL_RIGHT)) begin
         wpos_in = $signed({1'b0, wall_half_span});
      end else begin
         wpos_in = -$signed({1'b0, wall_half_span});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
      if (advance) begin
         s1_ch_ff   <= hd_in.c;
         s1_sh_ff   <= hd_in.s;
         s1_t_ff    <= axis_in ? th_in.s : th_in.c;
         s1_wpos_ff <= wpos_in;
         s1_axis_ff <= axis_in;
         s1_side_ff <= in_word.side;
      end
   end

   // stage 2: products
   logic                 s2_valid_ff;
   logic signed [36:0]   s2_pd_ff;
   logic signed [33:0]   s2_m1_ff, s2_m2_ff;
   logic signed [15:0]   s2_wpos_ff;
   logic                 s2_axis_ff;
   wdpr_pkg::side_type   s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_pd_ff   <= s1_t_ff * $signed({1'b0, s1_side_ff.dist_q8});
         s2_m1_ff   <= (s1_axis_ff ? s1_sh_ff : s1_ch_ff) * $signed(s1_side_ff.mount_x_offset);
         s2_m2_ff   <= (s1_axis_ff ? s1_ch_ff : s1_sh_ff) * $signed(s1_side_ff.mount_y_offset);
         s2_wpos_ff <= s1_wpos_ff;
         s2_axis_ff <= s1_axis_ff;
         s2_side_ff <= s1_side_ff;
      end
   end

   // stage 3: sum in Q15
   logic                 s3_valid_ff;
   logic signed [39:0]   s3_sum_ff;
   logic                 s3_axis_ff;
   wdpr_pkg::side_type   s3_side_ff;
   logic signed [39:0]   sum_in;
   logic signed [39:0]   m1_ext;

   always_comb begin
      m1_ext = {{6{s2_m1_ff[33]}}, s2_m1_ff};
      sum_in = {{9{s2_wpos_ff[15]}}, s2_wpos_ff, 15'd0}
             + {{3{s2_pd_ff[36]}}, s2_pd_ff}
             + (s2_axis_ff ? m1_ext : -m1_ext)
             - {{6{s2_m2_ff[33]}}, s2_m2_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_sum_ff  <= sum_in;
         s3_axis_ff <= s2_axis_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // stage 4: round, saturate, gate and apply
   logic                 out_valid_ff;
   wdpr_pkg::result_type out_ff;
   logic [39:0]          rnd;
   logic signed [24:0]   cand_wide;
   logic signed [15:0]   cand_sat, cand;
   logic signed [16:0]   diff;
   logic [16:0]          diff_abs;
   wdpr_pkg::result_type res_in;

   always_comb begin
      rnd       = s3_sum_ff + 40'sd16384;
      cand_wide = $signed(rnd[39:15]);
      if (cand_wide > 25'sd32767) begin
         cand_sat = 16'sh7FFF;
      end else if (cand_wide < -25'sd32768) begin
         cand_sat = 16'sh8000;
      end else begin
         cand_sat = cand_wide[15:0];
      end
      cand = s3_side_ff.sensor_present ? cand_sat : 16'sd0;
      diff = {cand[15], cand}
           - (s3_axis_ff ? {s3_side_ff.pose_y_in[15], s3_side_ff.pose_y_in}
                         : {s3_side_ff.pose_x_in[15], s3_side_ff.pose_x_in});
      diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
      res_in.candidate_pos = cand;
      res_in.axis_is_y     = s3_axis_ff;
      res_in.accepted      = diff_abs < {2'd0, s3_side_ff.gate_distance};
      res_in.pose_x_out    = (res_in.accepted && !s3_axis_ff) ? cand : s3_side_ff.pose_x_in;
      res_in.pose_y_out    = (res_in.accepted && s3_axis_ff) ? cand : s3_side_ff.pose_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         out_ff <= res_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_ff;

endmodule

// ===== hdl/wall_distance_pose_reset.sv =====
// Top level of the wall distance pose reset block.
// A request word passes through 21 register stages on its way to the response word:
// entry, 16 CORDIC, trig, product, sum and gate.
// Throughput: one word per cycle; the whole pipeline holds while the
// response register is full and not taken.
// Reset: synchronous; clears all stage valid bits and loads the wall span to 17920.
module wall_distance_pose_reset (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [14:0] csr_write_data,
   wdpr_req_if.sink    req,
   wdpr_rsp_if.source  rsp
);

   logic                 advance;
   logic [14:0]          span_ff;
   wdpr_pkg::side_type   side_in;
   logic                 rot_valid;
   wdpr_pkg::rot_type    rot_word;
   logic                 res_valid;
   wdpr_pkg::result_type res_word;

   // hold the wall span register
   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff <= wdpr_pkg::SPAN_RESET;
      end else if (csr_write_enable) begin
         span_ff <= csr_write_data;
      end
   end

   // advance the pipeline unless the response word is stuck
   assign advance   = !res_valid || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      side_in.dist_q8        = 18'd0;
      side_in.sensor_side    = req.sensor_side;
      side_in.wall_side      = req.wall_side;
      side_in.sensor_present = req.sensor_present;
      side_in.mount_x_offset = req.mount_x_offset;
      side_in.mount_y_offset = req.mount_y_offset;
      side_in.pose_x_in      = req.pose_x_in;
      side_in.pose_y_in      = req.pose_y_in;
      side_in.gate_distance  = req.gate_distance;
   end

   wdpr_cordic u_cordic (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req.valid),
      .heading     (req.heading),
      .distance_mm (req.distance_mm),
      .side_in     (side_in),
      .out_valid   (rot_valid),
      .out_word    (rot_word)
   );

   wdpr_post u_post (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .wall_half_span (span_ff),
      .in_valid       (rot_valid),
      .in_word        (rot_word),
      .out_valid      (res_valid),
      .out_word       (res_word)
   );

   assign rsp.valid         = res_valid;
   assign rsp.candidate_pos = res_word.candidate_pos;
   assign rsp.axis_is_y     = res_word.axis_is_y;
   assign rsp.accepted      = res_word.accepted;
   assign rsp.pose_x_out    = res_word.pose_x_out;
   assign rsp.pose_y_out    = res_word.pose_y_out;

   // checks
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.candidate_pos))
      else $error("response word changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("request ready does not follow response stall");
   a_apply_x: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.accepted && !rsp.axis_is_y |-> rsp.pose_x_out == rsp.candidate_pos)
      else $error("accepted x correction not applied");
   a_reset: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("response valid after reset");

endmodule
